@@ design/egml_pkg.sv @@
package egml_pkg;

    localparam int NODES_DEF  = 32;
    localparam int LEVELS_DEF = 32;

    localparam logic [1:0] CMD_EDGE  = 2'd0;
    localparam logic [1:0] CMD_EOG   = 2'd1;
    localparam logic [1:0] CMD_BATCH = 2'd2;

    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_MEM1 = 2'd1;
    localparam logic [1:0] KIND_MEM2 = 2'd2;
    localparam logic [1:0] KIND_OVF  = 2'd3;

    localparam logic CFG_LEVEL_LIMIT = 1'b0;
    localparam logic CFG_MEMBER_ON   = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] node_a;
        logic [4:0] node_b;
        logic       swap_ends;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] graph_index;
        logic [5:0]  level;
        logic [5:0]  level_first;
        logic [5:0]  level_second;
        logic [23:0] offset_first;
        logic [23:0] offset_second;
        logic [23:0] global_first;
        logic [23:0] global_second;
        logic        same_group;
        logic        last;
    } out_item_t;

endpackage

@@ design/egml_front.sv @@
// Input side: swaps ends, drops ignored commands, and holds two beats
module egml_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  egml_pkg::in_item_t  data_in,
    output logic                q_valid,
    input  logic                q_take,
    output egml_pkg::in_item_t  q_data
);
    egml_pkg::in_item_t slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    egml_pkg::in_item_t cooked;
    logic keep;
    logic do_push;
    logic do_pop;

    always_comb
    begin
        cooked = data_in;
        if (data_in.swap_ends)
        begin
            cooked.node_a = data_in.node_b;
            cooked.node_b = data_in.node_a;
        end
        cooked.swap_ends = 1'b0;
    end

    assign keep    = (data_in.command != 2'd3);
    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full && keep;
    assign do_pop  = q_take && (cnt_reg != 2'd0);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= cooked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
                wr_reg <= !wr_reg;
            if (do_pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !do_pop) |=> cnt_reg == 2'd2)
        else $error("queue lost a beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        do_push |-> data_in.command != 2'd3)
        else $error("ignored command queued");
endmodule

@@ design/egml_back.sv @@
// Carries out queued commands: table lookup, merge walk, and result output
module egml_back #(
    parameter int NODES  = egml_pkg::NODES_DEF,
    parameter int LEVELS = egml_pkg::LEVELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_take,
    input  egml_pkg::in_item_t  q_data,
    input  logic [5:0]          level_limit,
    input  logic                member_lists_on,
    output logic                empty,
    input  logic                pop,
    output egml_pkg::out_item_t result
);
    localparam int GW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW = $clog2(NODES * NODES);
    localparam logic [5:0] LEVELS6 = 6'(LEVELS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_EDGE = 3'd2;
    localparam logic [2:0] ST_W1   = 3'd3;
    localparam logic [2:0] ST_W2   = 3'd4;
    localparam logic [2:0] ST_CLR  = 3'd5;

    logic [2:0] st_reg;

    // per-graph tables, reset pattern restored on end of graph and new batch
    logic [GW-1:0] node_group_reg [NODES];
    logic [5:0]    group_level_reg [NODES];
    logic [23:0]   group_slot_reg [NODES];
    logic [CW-1:0] member_count_reg [NODES];
    // slots used per level 1..LEVELS; the node base stands apart
    logic [23:0]   level_count_reg [LEVELS];
    logic [23:0]   node_base_reg;
    logic [4:0]    member_mem [NODES*NODES];
    logic [4:0]    mem_rd_reg;
    logic [4:0]    max_node_reg;
    logic [15:0]   graph_reg;
    logic [GW-1:0] clr_reg;

    egml_pkg::in_item_t cur_reg;
    logic [GW-1:0] g1_reg, g2_reg;
    logic [5:0]    l1_reg, l2_reg;
    logic [6:0]    lvl_reg;
    logic [23:0]   slot_reg, base_reg;
    logic [CW-1:0] j_reg, n1_reg, n2_reg;
    logic          same_reg;
    logic          rd_pend_reg;

    egml_pkg::out_item_t out_reg;
    logic                out_full_reg;

    logic [GW-1:0] ga, gb;
    logic [5:0]    la, lb, lmax;
    logic [6:0]    lvl_c;
    logic          bad_node;
    logic          can_out;
    logic          out_load;
    logic [LW-1:0] lvl_idx;
    logic [CW-1:0] n1_end;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [4:0]    wr_data;

    assign empty   = !out_full_reg;
    assign result  = out_reg;
    assign can_out = !out_full_reg || pop;
    assign out_load = can_out && ((st_reg == ST_EDGE)
                                  || (st_reg == ST_W1 && rd_pend_reg)
                                  || (st_reg == ST_W2 && rd_pend_reg && member_lists_on));
    assign q_take  = (st_reg == ST_IDLE) && q_valid;
    assign ga      = node_group_reg[GW'(cur_reg.node_a)];
    assign gb      = node_group_reg[GW'(cur_reg.node_b)];
    assign la      = group_level_reg[ga];
    assign lb      = group_level_reg[gb];
    assign lmax    = (la > lb) ? la : lb;
    assign lvl_c   = {1'b0, lmax} + 7'd1;
    assign bad_node = (32'(cur_reg.node_a) >= NODES) || (32'(cur_reg.node_b) >= NODES);
    assign lvl_idx = LW'(lvl_reg - 7'd1);
    assign n1_end  = (32'(n1_reg) < NODES) ? n1_reg + CW'(1) : n1_reg;

    assign rd_addr = (st_reg == ST_W1) ? AW'(32'(g1_reg) * NODES + 32'(j_reg))
                                       : AW'(32'(g2_reg) * NODES + 32'(j_reg));
    assign wr_addr = (st_reg == ST_CLR) ? AW'(32'(clr_reg) * NODES)
                                        : AW'(32'(g1_reg) * NODES + 32'(n1_reg));
    assign wr_en   = (st_reg == ST_CLR)
                     || (st_reg == ST_W2 && rd_pend_reg && 32'(n1_reg) < NODES);
    assign wr_data = (st_reg == ST_CLR) ? 5'(clr_reg) : mem_rd_reg;

    always_ff @(posedge clk)
    begin
        // hold the fetched entry while its beat waits
        if (!rd_pend_reg)
            mem_rd_reg <= member_mem[rd_addr];
        if (wr_en)
            member_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLR;
            clr_reg       <= '0;
            out_full_reg  <= 1'b0;
            max_node_reg  <= '0;
            graph_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            node_base_reg <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                node_group_reg[i]   <= GW'(i);
                group_level_reg[i]  <= '0;
                group_slot_reg[i]   <= 24'(i);
                member_count_reg[i] <= CW'(1);
            end
            for (int i = 0; i < LEVELS; i++)
                level_count_reg[i] <= '0;
        end
        else
        begin
            if (out_load)
                out_full_reg <= 1'b1;
            else if (pop)
                out_full_reg <= 1'b0;
            case (st_reg)
                ST_CLR:
                begin
                    // sweep member rows back to their own node
                    clr_reg <= clr_reg + GW'(1);
                    if (32'(clr_reg) == NODES - 1)
                        st_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_data.command == egml_pkg::CMD_EDGE)
                        begin
                            cur_reg <= q_data;
                            st_reg  <= ST_LOOK;
                        end
                        else
                        begin
                            if (q_data.command == egml_pkg::CMD_EOG)
                            begin
                                node_base_reg <= node_base_reg
                                    + 24'(max_node_reg) + 24'd1;
                                graph_reg <= graph_reg + 16'd1;
                            end
                            else
                            begin
                                for (int i = 0; i < LEVELS; i++)
                                    level_count_reg[i] <= '0;
                                node_base_reg <= '0;
                                graph_reg     <= '0;
                            end
                            for (int i = 0; i < NODES; i++)
                            begin
                                node_group_reg[i]   <= GW'(i);
                                group_level_reg[i]  <= '0;
                                group_slot_reg[i]   <= 24'(i);
                                member_count_reg[i] <= CW'(1);
                            end
                            max_node_reg <= '0;
                            clr_reg      <= '0;
                            st_reg       <= ST_CLR;
                        end
                    end
                end
                ST_LOOK:
                begin
                    if (bad_node)
                        st_reg <= ST_IDLE;
                    else
                    begin
                        if (cur_reg.node_a > max_node_reg && cur_reg.node_a >= cur_reg.node_b)
                            max_node_reg <= cur_reg.node_a;
                        else if (cur_reg.node_b > max_node_reg)
                            max_node_reg <= cur_reg.node_b;
                        g1_reg   <= ga;
                        g2_reg   <= gb;
                        l1_reg   <= la;
                        l2_reg   <= lb;
                        lvl_reg  <= lvl_c;
                        same_reg <= (ga == gb);
                        base_reg <= node_base_reg;
                        if (level_limit != 6'd0 && lvl_c > {1'b0, level_limit})
                            st_reg <= ST_IDLE;
                        else
                            st_reg <= ST_EDGE;
                    end
                end
                ST_EDGE:
                begin
                    if (can_out)
                    begin
                        out_reg.graph_index   <= graph_reg;
                        out_reg.level_first   <= l1_reg;
                        out_reg.level_second  <= l2_reg;
                        out_reg.offset_first  <= group_slot_reg[g1_reg]
                            + ((l1_reg == 6'd0) ? base_reg : 24'd0);
                        out_reg.offset_second <= group_slot_reg[g2_reg]
                            + ((l2_reg == 6'd0) ? base_reg : 24'd0);
                        out_reg.global_first  <= base_reg + 24'(cur_reg.node_a);
                        out_reg.global_second <= base_reg + 24'(cur_reg.node_b);
                        out_reg.same_group    <= same_reg;
                        if (lvl_reg > {1'b0, LEVELS6})
                        begin
                            out_reg.kind  <= egml_pkg::KIND_OVF;
                            out_reg.level <= (lvl_reg > 7'd63) ? 6'd63 : 6'(lvl_reg);
                            out_reg.last  <= 1'b1;
                            st_reg        <= ST_IDLE;
                        end
                        else
                        begin
                            out_reg.kind  <= egml_pkg::KIND_EDGE;
                            out_reg.level <= 6'(lvl_reg);
                            out_reg.last  <= same_reg || !member_lists_on;
                            slot_reg <= level_count_reg[lvl_idx];
                            level_count_reg[lvl_idx] <= level_count_reg[lvl_idx] + 24'd1;
                            group_level_reg[g1_reg] <= 6'(lvl_reg);
                            group_slot_reg[g1_reg]  <= level_count_reg[lvl_idx];
                            n1_reg <= member_count_reg[g1_reg];
                            n2_reg <= member_count_reg[g2_reg];
                            j_reg  <= '0;
                            rd_pend_reg <= 1'b0;
                            if (same_reg)
                                st_reg <= ST_IDLE;
                            else if (member_lists_on)
                                st_reg <= ST_W1;
                            else
                                st_reg <= ST_W2;
                        end
                    end
                end
                ST_W1:
                begin
                    // read of entry j issued this cycle, emitted once the output register can take it
                    if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                        j_reg       <= j_reg + CW'(1);
                    end
                    else if (can_out)
                    begin
                        out_reg.kind          <= egml_pkg::KIND_MEM1;
                        out_reg.graph_index   <= graph_reg;
                        out_reg.level         <= 6'(lvl_reg - 7'd1);
                        out_reg.level_first   <= '0;
                        out_reg.level_second  <= '0;
                        out_reg.offset_first  <= slot_reg;
                        out_reg.offset_second <= '0;
                        out_reg.global_first  <= base_reg + 24'(mem_rd_reg);
                        out_reg.global_second <= '0;
                        out_reg.same_group    <= 1'b0;
                        out_reg.last          <= 1'b0;
                        rd_pend_reg           <= 1'b0;
                        if (j_reg >= n1_reg || 32'(j_reg) >= NODES)
                        begin
                            j_reg  <= '0;
                            st_reg <= ST_W2;
                        end
                    end
                end
                ST_W2:
                begin
                    if (!rd_pend_reg)
                    begin
                        if (j_reg >= n2_reg || 32'(j_reg) >= NODES)
                        begin
                            member_count_reg[g1_reg] <= n1_reg;
                            st_reg <= ST_IDLE;
                        end
                        else
                            rd_pend_reg <= 1'b1;
                    end
                    else if (can_out || !member_lists_on)
                    begin
                        if (member_lists_on)
                        begin
                            out_reg.kind          <= egml_pkg::KIND_MEM2;
                            out_reg.graph_index   <= graph_reg;
                            out_reg.level         <= 6'(lvl_reg - 7'd1);
                            out_reg.level_first   <= '0;
                            out_reg.level_second  <= '0;
                            out_reg.offset_first  <= slot_reg;
                            out_reg.offset_second <= '0;
                            out_reg.global_first  <= base_reg + 24'(mem_rd_reg);
                            out_reg.global_second <= '0;
                            out_reg.same_group    <= 1'b0;
                            out_reg.last <= (j_reg + CW'(1) >= n2_reg)
                                || (32'(j_reg) + 1 >= NODES);
                        end
                        n1_reg <= n1_end;
                        if (32'(mem_rd_reg) < NODES)
                            node_group_reg[GW'(mem_rd_reg)] <= g1_reg;
                        j_reg       <= j_reg + CW'(1);
                        rd_pend_reg <= 1'b0;
                    end
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !pop) |=> $stable(out_reg))
        else $error("waiting result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> st_reg == ST_IDLE)
        else $error("queue read while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_W1 || st_reg == ST_W2) |-> !same_reg)
        else $error("walk on a single group");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_LOOK) |=> !(st_reg == ST_LOOK))
        else $error("lookup stuck");
endmodule

@@ design/edge_group_merge_leveler_core.sv @@
// Edge group merge leveler. Commands enter through a two-beat queue; an
// edge is issued, looked up and recorded; unless both ends share a group
// or the level overflows, a walk then reads each member of the second group
// (after each member of the first when member lists are on) and closes. The
// two groups hold at most NODES members together, read through the single
// read port of the member store; a beat that meets a full output register
// waits there for pop. End of graph and new batch are taken in idle, then a
// sweep over the NODES member store rows restores them; during it no command
// is taken. The same sweep runs once after reset.
module edge_group_merge_leveler_core #(
    parameter int NODES  = egml_pkg::NODES_DEF,
    parameter int LEVELS = egml_pkg::LEVELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  egml_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output egml_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [5:0]          cfg_data
);
    logic [5:0] level_limit_reg;
    logic       member_on_reg;
    logic       q_valid;
    logic       q_take_b;
    egml_pkg::in_item_t q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_limit_reg <= '0;
            member_on_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == egml_pkg::CFG_LEVEL_LIMIT)
                level_limit_reg <= cfg_data;
            else
                member_on_reg <= cfg_data[0];
        end
    end

    egml_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .data_in (in_item),
        .q_valid (q_valid),
        .q_take  (q_take_b),
        .q_data  (q_data)
    );

    egml_back #(.NODES(NODES), .LEVELS(LEVELS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_take          (q_take_b),
        .q_data          (q_data),
        .level_limit     (level_limit_reg),
        .member_lists_on (member_on_reg),
        .empty           (empty),
        .pop             (pop),
        .result          (out_item)
    );
endmodule

@@ verif/tb.sv @@
module tb;

    localparam int WATCH_LIMIT = 4000;
    localparam int SETTLE      = 150;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    egml_pkg::in_item_t  in_item;
    logic        empty;
    logic        pop;
    egml_pkg::out_item_t out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [5:0]  cfg_data;

    edge_group_merge_leveler_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow state of the merge engine
    logic [4:0]  node_grp [32];
    logic [5:0]  grp_level [32];
    logic [23:0] grp_slot [32];
    logic [4:0]  grp_members [32][32];
    int          grp_size [32];
    logic [23:0] slots_used [33];
    logic [4:0]  top_node;
    logic [15:0] graph_no;
    logic [5:0]  lim;
    logic        members_on;

    egml_pkg::out_item_t pending_records[$];
    int          mismatches;
    bit          quiet;
    int          hold_trigger;
    int          graph_span;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_graph();
        for (int g = 0; g < 32; g++)
        begin
            node_grp[g]  = g[4:0];
            grp_level[g] = '0;
            grp_slot[g]  = 24'(g);
            for (int j = 0; j < 32; j++)
                grp_members[g][j] = '0;
            grp_members[g][0] = g[4:0];
            grp_size[g]  = 1;
        end
        top_node = '0;
    endfunction

    function automatic void clear_batch();
        clear_graph();
        for (int l = 0; l < 33; l++)
            slots_used[l] = '0;
        graph_no = '0;
    endfunction

    function automatic egml_pkg::out_item_t member_rec(logic [1:0] k, int lvl,
                                                       logic [23:0] slot,
                                                       logic [23:0] glob);
        egml_pkg::out_item_t r;
        r = '0;
        r.kind         = k;
        r.graph_index  = graph_no;
        r.level        = 6'(lvl - 1);
        r.offset_first = slot;
        r.global_first = glob;
        return r;
    endfunction

    function automatic void merge_predict(egml_pkg::in_item_t it,
                                          ref egml_pkg::out_item_t recs[$]);
        logic [4:0]  f;
        logic [4:0]  s;
        logic [4:0]  g1;
        logic [4:0]  g2;
        int          l1;
        int          l2;
        int          lvl;
        logic [23:0] base;
        logic [23:0] slot;
        logic [4:0]  node;
        egml_pkg::out_item_t r;
        recs = {};
        if (it.command == egml_pkg::CMD_EOG)
        begin
            slots_used[0] = slots_used[0] + 24'(top_node) + 24'd1;
            graph_no = graph_no + 16'd1;
            clear_graph();
            return;
        end
        if (it.command == egml_pkg::CMD_BATCH)
        begin
            clear_batch();
            return;
        end
        if (it.command != egml_pkg::CMD_EDGE)
            return;
        f = it.swap_ends ? it.node_b : it.node_a;
        s = it.swap_ends ? it.node_a : it.node_b;
        if (f > top_node) top_node = f;
        if (s > top_node) top_node = s;
        g1 = node_grp[f];
        g2 = node_grp[s];
        l1 = int'(grp_level[g1]);
        l2 = int'(grp_level[g2]);
        lvl = ((l1 > l2) ? l1 : l2) + 1;
        if (lim != 6'd0 && lvl > int'(lim))
            return;
        base = slots_used[0];
        r = '0;
        r.graph_index   = graph_no;
        r.level_first   = 6'(l1);
        r.level_second  = 6'(l2);
        r.offset_first  = grp_slot[g1] + ((l1 == 0) ? base : 24'd0);
        r.offset_second = grp_slot[g2] + ((l2 == 0) ? base : 24'd0);
        r.global_first  = base + 24'(f);
        r.global_second = base + 24'(s);
        r.same_group    = (g1 == g2);
        if (lvl > 32)
        begin
            r.kind  = egml_pkg::KIND_OVF;
            r.level = (lvl > 63) ? 6'd63 : 6'(lvl);
            r.last  = 1'b1;
            recs = {recs, r};
            return;
        end
        r.kind  = egml_pkg::KIND_EDGE;
        r.level = 6'(lvl);
        recs = {recs, r};
        slot = slots_used[lvl];
        grp_level[g1] = 6'(lvl);
        grp_slot[g1]  = slot;
        slots_used[lvl] = slot + 24'd1;
        if (g1 != g2)
        begin
            if (members_on)
                for (int j = 0; j < grp_size[g1]; j++)
                    recs = {recs, member_rec(egml_pkg::KIND_MEM1, lvl, slot,
                                             base + 24'(grp_members[g1][j]))};
            for (int j = 0; j < grp_size[g2]; j++)
            begin
                node = grp_members[g2][j];
                if (members_on)
                    recs = {recs, member_rec(egml_pkg::KIND_MEM2, lvl, slot,
                                             base + 24'(node))};
                if (grp_size[g1] < 32)
                begin
                    grp_members[g1][grp_size[g1]] = node;
                    grp_size[g1]++;
                end
                node_grp[node] = g1;
            end
        end
        recs[recs.size() - 1].last = 1'b1;
    endfunction

    task automatic field_check(input string name, input logic [23:0] want,
                               input logic [23:0] got, inout bit bad);
        if (want !== got)
        begin
            if (!bad)
                mismatches++;
            bad = 1'b1;
            if (mismatches <= 10)
                $display("mismatch %0t %s: expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // receiver: check each popped beat, then pick the next pop value
    initial
    begin
        int        hold_left;
        int        hold_seen;
        egml_pkg::out_item_t want;
        bit        bad;
        hold_left = 0;
        hold_seen = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_records.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected record %0t: expected none got %p",
                                 $time, out_item);
                end
                else
                begin
                    want = pending_records.pop_front();
                    bad = 1'b0;
                    field_check("kind", 24'(want.kind), 24'(out_item.kind), bad);
                    field_check("graph_index", 24'(want.graph_index),
                                24'(out_item.graph_index), bad);
                    field_check("level", 24'(want.level), 24'(out_item.level), bad);
                    field_check("level_first", 24'(want.level_first),
                                24'(out_item.level_first), bad);
                    field_check("level_second", 24'(want.level_second),
                                24'(out_item.level_second), bad);
                    field_check("offset_first", want.offset_first,
                                out_item.offset_first, bad);
                    field_check("offset_second", want.offset_second,
                                out_item.offset_second, bad);
                    field_check("global_first", want.global_first,
                                out_item.global_first, bad);
                    field_check("global_second", want.global_second,
                                out_item.global_second, bad);
                    field_check("same_group", 24'(want.same_group),
                                24'(out_item.same_group), bad);
                    field_check("last", 24'(want.last), 24'(out_item.last), bad);
                end
            end
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
        end
    end

    // watchdog on cycles without any accepted beat
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic offer(input egml_pkg::in_item_t it, input bit typed,
                         input egml_pkg::out_item_t want);
        egml_pkg::out_item_t recs[$];
        push    <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        merge_predict(it, recs);
        if (typed)
            pending_records = {pending_records, want};
        else
            pending_records = {pending_records, recs};
        if (!quiet && $urandom_range(99) < 38)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send(input logic [1:0] c, input int a, input int b, input bit sw);
        egml_pkg::in_item_t it;
        it.command   = c;
        it.node_a    = a[4:0];
        it.node_b    = b[4:0];
        it.swap_ends = sw;
        offer(it, 1'b0, '0);
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [5:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == egml_pkg::CFG_LEVEL_LIMIT)
            lim = v;
        else
            members_on = v[0];
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        int a;
        int b;
        pick = $urandom_range(99);
        a = $urandom_range(graph_span - 1);
        b = $urandom_range(graph_span - 1);
        if (pick < 7)
        begin
            send(egml_pkg::CMD_EOG, $urandom_range(31), $urandom_range(31),
                 1'($urandom_range(1)));
            graph_span = ($urandom_range(3) == 0) ? 32 : $urandom_range(2, 10);
        end
        else if (pick < 9)
            send(egml_pkg::CMD_BATCH, $urandom_range(31), $urandom_range(31),
                 1'($urandom_range(1)));
        else if (pick < 11)
            send(2'd3, $urandom_range(31), $urandom_range(31), 1'($urandom_range(1)));
        else if (pick < 20)
            send(egml_pkg::CMD_EDGE, a, a, 1'($urandom_range(1)));
        else
            send(egml_pkg::CMD_EDGE, a, b, 1'($urandom_range(1)));
    endtask

    typedef struct {
        egml_pkg::in_item_t  item;
        bit                  typed;
        egml_pkg::out_item_t want;
    } stim_row_t;

    initial
    begin
        stim_row_t opening[$];
        stim_row_t row;
        egml_pkg::in_item_t extra_items [11];
        logic [5:0] phase_lim [6];
        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = egml_pkg::CFG_LEVEL_LIMIT;
        cfg_data  = '0;
        quiet     = 1'b0;
        hold_trigger = 0;
        mismatches = 0;
        graph_span = 6;
        lim = '0;
        members_on = 1'b0;
        clear_batch();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // first edge after reset, a wrapped-around swapped edge and a self loop
        row = '{item: '{egml_pkg::CMD_EDGE, 5'd0, 5'd1, 1'b0}, typed: 1'b1,
                want: '{egml_pkg::KIND_EDGE, 16'd0, 6'd1, 6'd0, 6'd0, 24'd0, 24'd1,
                        24'd0, 24'd1, 1'b0, 1'b1}};
        opening = {opening, row};
        row = '{item: '{egml_pkg::CMD_EOG, 5'd0, 5'd0, 1'b0}, typed: 1'b0, want: '0};
        opening = {opening, row};
        row = '{item: '{egml_pkg::CMD_EDGE, 5'd31, 5'd0, 1'b1}, typed: 1'b1,
                want: '{egml_pkg::KIND_EDGE, 16'd1, 6'd1, 6'd0, 6'd0, 24'd2, 24'd33,
                        24'd2, 24'd33, 1'b0, 1'b1}};
        opening = {opening, row};
        row = '{item: '{egml_pkg::CMD_EDGE, 5'd5, 5'd5, 1'b0}, typed: 1'b1,
                want: '{egml_pkg::KIND_EDGE, 16'd1, 6'd1, 6'd0, 6'd0, 24'd7, 24'd7,
                        24'd7, 24'd7, 1'b1, 1'b1}};
        opening = {opening, row};
        extra_items = '{'{2'd3, 5'd31, 5'd31, 1'b1},
                        '{egml_pkg::CMD_EDGE, 5'd31, 5'd5, 1'b0},
                        '{egml_pkg::CMD_EDGE, 5'd1, 5'd2, 1'b1},
                        '{egml_pkg::CMD_EDGE, 5'd2, 5'd31, 1'b0},
                        '{egml_pkg::CMD_EDGE, 5'd0, 5'd5, 1'b0},
                        '{egml_pkg::CMD_EDGE, 5'd21, 5'd10, 1'b1},
                        '{egml_pkg::CMD_EOG, 5'd31, 5'd31, 1'b1},
                        '{egml_pkg::CMD_EOG, 5'd0, 5'd0, 1'b0},
                        '{egml_pkg::CMD_EDGE, 5'd30, 5'd31, 1'b0},
                        '{egml_pkg::CMD_BATCH, 5'd0, 5'd0, 1'b0},
                        '{egml_pkg::CMD_EDGE, 5'd3, 5'd4, 1'b0}};
        foreach (extra_items[i])
        begin
            row.item  = extra_items[i];
            row.typed = 1'b0;
            row.want  = '0;
            opening = {opening, row};
        end
        foreach (opening[i])
            offer(opening[i].item, opening[i].typed, opening[i].want);
        settle();

        // member lists on: merges of grown groups, then a self-loop climb past the top level
        cfg_write(egml_pkg::CFG_MEMBER_ON, 6'd1);
        for (int n = 1; n < 32; n++)
            send(egml_pkg::CMD_EDGE, 0, n, n[0]);
        send(egml_pkg::CMD_EDGE, 31, 0, 1'b0);
        send(egml_pkg::CMD_BATCH, 0, 0, 1'b0);
        for (int n = 0; n < 34; n++)
            send(egml_pkg::CMD_EDGE, 7, 7, 1'b0);
        settle();

        // level limit low: deep merges get dropped
        cfg_write(egml_pkg::CFG_LEVEL_LIMIT, 6'd1);
        send(egml_pkg::CMD_BATCH, 0, 0, 1'b0);
        for (int n = 0; n < 6; n++)
            send(egml_pkg::CMD_EDGE, n, n + 1, 1'b0);
        settle();

        // random phases over several settings
        phase_lim = '{6'd32, 6'd5, 6'd10, 6'd26, 6'd0, 6'd0};
        foreach (phase_lim[p])
        begin
            cfg_write(egml_pkg::CFG_LEVEL_LIMIT, phase_lim[p]);
            cfg_write(egml_pkg::CFG_MEMBER_ON, 6'(p % 2 == 0));
            quiet = (p == 3);
            if (p == 1)
                hold_trigger++;
            for (int n = 0; n < 50; n++)
            begin
                if (p == 4 && n == 25)
                begin
                    // pause the sender until the block has drained
                    push <= 1'b0;
                    @(posedge clk);
                    while (pending_records.size() != 0)
                        @(posedge clk);
                end
                random_item();
            end
            settle();
        end
        quiet = 1'b0;

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
